// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)

`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// ===== src/esd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_marker;
  } out_word_t;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_OCTAL  = 2'd2,
    MODE_HEX    = 2'd3
  } mode_t;

  // Decoder to queue: up to two words per input word.
  typedef struct packed {
    logic [1:0] push_cnt;
    out_word_t  w0;
    out_word_t  w1;
  } dec_res_t;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LX     = 8'h78;

  localparam logic [7:0] CTL_BEL = 8'h07;
  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_LF  = 8'h0A;
  localparam logic [7:0] CTL_CR  = 8'h0D;
  localparam logic [7:0] CTL_TAB = 8'h09;

  localparam logic [7:0] HEX_TEN = 8'd10;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // {valid, value} of a hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] t;
    logic [4:0] r;
    t = 8'd0;
    r = 5'd0;
    if (c >= CH_0 && c <= CH_9) begin
      t = c - CH_0;
      r = {1'b1, t[3:0]};
    end else if (c >= CH_UA && c <= CH_UF) begin
      t = c - CH_UA + HEX_TEN;
      r = {1'b1, t[3:0]};
    end else if (c >= CH_LA && c <= CH_LF) begin
      t = c - CH_LA + HEX_TEN;
      r = {1'b1, t[3:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/esd_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module esd_decode
  import esd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     accept,
  input  wire in_word_t in_word,
  output dec_res_t      res
);

  mode_t      mode_r, mode_nxt;
  logic [7:0] run_r, run_nxt;
  logic [7:0] c;
  logic [4:0] hd;
  out_word_t  run_w, chr_w, end_w;

  assign c     = in_word.char_byte;
  assign hd    = hex_digit(c);
  assign run_w = '{out_byte: run_r, end_marker: 1'b0};
  assign chr_w = '{out_byte: c, end_marker: 1'b0};
  assign end_w = '{out_byte: 8'd0, end_marker: 1'b1};

  always_comb begin
    mode_nxt     = mode_r;
    run_nxt      = run_r;
    res.push_cnt = 2'd0;
    res.w0       = '0;
    res.w1       = '0;
    if (in_word.kind == KIND_END) begin
      mode_nxt = MODE_NORMAL;
      run_nxt  = 8'd0;
      case (mode_r) inside
        MODE_OCTAL, MODE_HEX: begin
          res.w0       = run_w;
          res.w1       = end_w;
          res.push_cnt = 2'd2;
        end
        default: begin
          res.w0       = end_w;
          res.push_cnt = 2'd1;
        end
      endcase
    end else begin
      unique case (mode_r)
        MODE_NORMAL: begin
          if (c == CH_BSLASH) begin
            mode_nxt = MODE_ESCAPE;
          end else begin
            res.w0       = chr_w;
            res.push_cnt = 2'd1;
          end
        end
        MODE_ESCAPE: begin
          mode_nxt     = MODE_NORMAL;
          res.push_cnt = 2'd1;
          res.w0       = chr_w;
          unique case (c)
            CH_LA: res.w0.out_byte = CTL_BEL;
            CH_LB: res.w0.out_byte = CTL_BS;
            CH_LN: res.w0.out_byte = CTL_LF;
            CH_LR: res.w0.out_byte = CTL_CR;
            CH_LT: res.w0.out_byte = CTL_TAB;
            CH_0: begin
              res.push_cnt = 2'd0;
              run_nxt      = 8'd0;
              mode_nxt     = MODE_OCTAL;
            end
            CH_LX: begin
              res.push_cnt = 2'd0;
              run_nxt      = 8'd0;
              mode_nxt     = MODE_HEX;
            end
            default: res.w0 = chr_w;
          endcase
        end
        MODE_OCTAL, MODE_HEX: begin
          if (mode_r == MODE_OCTAL && c >= CH_0 && c <= CH_7) begin
            run_nxt = {run_r[4:0], c[2:0]};
          end else if (mode_r == MODE_HEX && hd[4]) begin
            run_nxt = {run_r[3:0], hd[3:0]};
          end else begin
            // run ends; the terminating byte is handled as plain text
            res.w0   = run_w;
            run_nxt  = 8'd0;
            mode_nxt = MODE_NORMAL;
            if (c == CH_BSLASH) begin
              mode_nxt     = MODE_ESCAPE;
              res.push_cnt = 2'd1;
            end else begin
              res.w1       = chr_w;
              res.push_cnt = 2'd2;
            end
          end
        end
        default: begin
          mode_nxt = MODE_NORMAL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      run_r  <= 8'd0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      run_r  <= run_nxt;
    end
  end

  `ASSERT_CLK(a_end_clears, clk, rst_n, (accept && in_word.kind == KIND_END) |=> (mode_r == MODE_NORMAL && run_r == 8'd0), "end of string must clear decode state")
  `ASSERT_CLK(a_escape_no_out, clk, rst_n, (accept && in_word.kind == KIND_CHAR && mode_r == MODE_NORMAL && c == CH_BSLASH) |-> (res.push_cnt == 2'd0), "backslash in text must emit nothing")
  `ASSERT_CLK(a_two_only_run, clk, rst_n, (res.push_cnt == 2'd2) |-> (mode_r == MODE_OCTAL || mode_r == MODE_HEX), "two words only when a run ends")

endmodule

`default_nettype wire

// ===== src/esd_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module esd_outq
  import esd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire dec_res_t  push,
  input  wire logic      pop,
  output logic           space_ok,
  output logic           head_vld,
  output out_word_t      head_word
);

  out_word_t            mem_r [QDEPTH];
  logic [QAW-1:0]       head_r, head_nxt;
  logic [QAW-1:0]       tail_r, tail_nxt;
  logic [QCW-1:0]       count_r, count_nxt;
  logic [QAW-1:0]       tail_p1;

  assign tail_p1   = tail_r + QAW'(1);
  assign space_ok  = count_r <= QCW'(QDEPTH - 2);
  assign head_vld  = count_r != '0;
  assign head_word = mem_r[head_r];

  always_comb begin
    head_nxt  = head_r + QAW'(pop);
    tail_nxt  = tail_r + QAW'(push.push_cnt);
    count_nxt = count_r + QCW'(push.push_cnt) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.push_cnt != 2'd0) begin
      mem_r[tail_r] <= push.w0;
    end
    if (push.push_cnt == 2'd2) begin
      mem_r[tail_p1] <= push.w1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  `ASSERT_NEVER(a_overflow, clk, rst_n, count_r > QCW'(QDEPTH), "word queue overflow")
  `ASSERT_CLK(a_push_space, clk, rst_n, (push.push_cnt != 2'd0) |-> space_ok, "push without room for two words")
  `ASSERT_CLK(a_pop_nonempty, clk, rst_n, pop |-> head_vld, "pop from empty queue")
  `ASSERT_NEVER(a_bad_cnt, clk, rst_n, push.push_cnt == 2'd3, "illegal push count")

endmodule

`default_nettype wire

// ===== src/escape_sequence_decoder.sv =====
// Escape sequence decoder.
// Input channel: one word per text byte (kind 0) or an end-of-string word
// (kind 1); accepted on a clock edge with in_valid high and in_stall low.
// Output channel: decoded bytes in order, followed by an end marker word
// for every end-of-string input; taken on out_valid high and out_stall low.
// Backslash escapes are decoded; octal and hex runs emit one byte when a
// non-digit or end of string ends them.
// Results are written into the output queue; out_* shows its head.
// Throughput: one input word per cycle while out_stall is low and each
// word yields at most one result; a word that closes a run yields two, so
// the four-entry output queue drains one word per cycle and in_stall rises
// when fewer than two entries are free.
// When the receiver stalls, queued words hold and the input keeps being
// taken until the queue is nearly full.
// Reset (rst_n low, synchronous) empties the queue and returns the decoder
// to plain text mode with a zero run value.
`timescale 1ns / 1ps
`default_nettype none

module escape_sequence_decoder
  import esd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  logic     accept;
  logic     space_ok;
  logic     pop;
  dec_res_t res;
  dec_res_t push;

  assign in_stall = !space_ok;
  assign accept   = in_valid && space_ok;
  assign pop      = out_valid && !out_stall;

  always_comb begin
    push = res;
    if (!accept) begin
      push.push_cnt = 2'd0;
    end
  end

  esd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_word (in_word),
    .res     (res)
  );

  esd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .space_ok  (space_ok),
    .head_vld  (out_valid),
    .head_word (out_word)
  );

endmodule

`default_nettype wire
